FILE: sv/sha1_message_digest_assert.svh
// Assertion helpers for the SHA-1 digest block.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SHA1MD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1md assertion failed");

// Next-cycle implication, checked outside reset.
`define SHA1MD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1md assertion failed");

`endif

FILE: sv/sha1md_pkg.sv
package sha1md_pkg;

  // byte source for the block buffer
  localparam logic [1:0] BSEL_IN   = 2'd0;
  localparam logic [1:0] BSEL_MARK = 2'd1;
  localparam logic [1:0] BSEL_ZERO = 2'd2;
  localparam logic [1:0] BSEL_LEN  = 2'd3;

  // round function groups
  localparam logic [1:0] FN_CH   = 2'd0;
  localparam logic [1:0] FN_PAR1 = 2'd1;
  localparam logic [1:0] FN_MAJ  = 2'd2;
  localparam logic [1:0] FN_PAR3 = 2'd3;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

  typedef struct packed {
    logic       put;        // write one byte into the block buffer
    logic [1:0] bsel;       // which byte
    logic       start;      // load working vars from chain value
    logic       round;      // run one round
    logic [1:0] fn;         // round function group
    logic       add;        // fold working vars into chain value
    logic       out_shift;  // digest word taken, shift chain
    logic [2:0] out_idx;    // index of the word being taken
    logic       clear;      // end of message, clear counters
  } sha1md_cmd_t;

  typedef struct packed {
    logic pos_last;     // byte position 63
    logic pos_pre_len;  // byte position 55
  } sha1md_sts_t;

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0:    w = 32'h67452301;
      3'd1:    w = 32'hefcdab89;
      3'd2:    w = 32'h98badcfe;
      3'd3:    w = 32'h10325476;
      3'd4:    w = 32'hc3d2e1f0;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] k_const(input logic [1:0] fn);
    logic [31:0] k;
    case (fn)
      FN_CH:   k = 32'h5A827999;
      FN_PAR1: k = 32'h6ED9EBA1;
      FN_MAJ:  k = 32'h8F1BBCDC;
      FN_PAR3: k = 32'hCA62C1D6;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] f_func(input logic [1:0] fn, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (fn)
      FN_CH:   f = (b & c) | (~b & d);
      FN_MAJ:  f = (b & c) | (b & d) | (c & d);
      FN_PAR1: f = b ^ c ^ d;
      FN_PAR3: f = b ^ c ^ d;
      default: f = 32'h0;
    endcase
    return f;
  endfunction

endpackage

FILE: sv/sha1md_dp.sv
module sha1md_dp import sha1md_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  sha1md_cmd_t cmd,
  input  logic [7:0]  in_data_byte,
  output sha1md_sts_t sts,
  output logic [31:0] digest_word
);

  logic [5:0]  pos_r;
  logic [63:0] len_r;
  logic [23:0] acc_r;
  logic [31:0] sched_r [16];
  logic [31:0] v_r     [5];
  logic [31:0] chain_r [5];

  logic [7:0]  byte_val;
  logic [31:0] w_mix, w_new, t_val;

  always_comb begin
    case (cmd.bsel)
      BSEL_IN:   byte_val = in_data_byte;
      BSEL_MARK: byte_val = PAD_MARK_BYTE;
      BSEL_ZERO: byte_val = 8'h00;
      BSEL_LEN:  byte_val = len_r[63:56];
      default:   byte_val = 8'h00;
    endcase
  end

  assign w_mix = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign t_val = {v_r[0][26:0], v_r[0][31:27]} + f_func(cmd.fn, v_r[1], v_r[2], v_r[3])
               + v_r[4] + k_const(cmd.fn) + sched_r[0];

  assign sts.pos_last    = (pos_r == 6'd63);
  assign sts.pos_pre_len = (pos_r == 6'd55);
  assign digest_word     = chain_r[0];

  // counters and chain value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
      for (int i = 0; i < 5; i++) chain_r[i] <= init_word(3'(i));
    end else begin
      if (cmd.clear) begin
        pos_r <= '0;
        len_r <= '0;
      end else if (cmd.put) begin
        pos_r <= pos_r + 6'd1;
        if (cmd.bsel == BSEL_IN) len_r <= len_r + 64'd8;
        else if (cmd.bsel == BSEL_LEN) len_r <= {len_r[55:0], 8'h00};
      end
      if (cmd.add) begin
        for (int i = 0; i < 5; i++) chain_r[i] <= chain_r[i] + v_r[i];
      end else if (cmd.out_shift) begin
        for (int i = 0; i < 4; i++) chain_r[i] <= chain_r[i+1];
        chain_r[4] <= init_word(cmd.out_idx);
      end
    end
  end

  // schedule shift line, byte packer, working vars
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      acc_r <= {acc_r[15:0], byte_val};
      if (pos_r[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) sched_r[i] <= sched_r[i+1];
        sched_r[15] <= {acc_r, byte_val};
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) sched_r[i] <= sched_r[i+1];
      sched_r[15] <= w_new;
    end
    if (cmd.start) begin
      for (int i = 0; i < 5; i++) v_r[i] <= chain_r[i];
    end else if (cmd.round) begin
      v_r[4] <= v_r[3];
      v_r[3] <= v_r[2];
      v_r[2] <= {v_r[1][1:0], v_r[1][31:2]};
      v_r[1] <= v_r[0];
      v_r[0] <= t_val;
    end
  end

endmodule

FILE: sv/sha1md_ctrl.sv
module sha1md_ctrl import sha1md_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_word_index,
  output logic        out_final_word,
  input  sha1md_sts_t sts,
  output sha1md_cmd_t cmd
);

  `include "sha1_message_digest_assert.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_MARK  = 3'd3;
  localparam logic [2:0] ST_ZERO  = 3'd4;
  localparam logic [2:0] ST_LEN   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_WORD  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] ret_r, ret_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = (state_r == ST_OUT);
  assign out_word_index = idx_r;
  assign out_final_word = (idx_r == LAST_WORD);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ret_nxt   = ret_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    if (rnd_r < 7'd20)      cmd.fn = FN_CH;
    else if (rnd_r < 7'd40) cmd.fn = FN_PAR1;
    else if (rnd_r < 7'd60) cmd.fn = FN_MAJ;
    else                    cmd.fn = FN_PAR3;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.put  = in_has_byte;
          cmd.bsel = BSEL_IN;
          if (in_has_byte && sts.pos_last) begin
            cmd.start = 1'b1;
            state_nxt = ST_ROUND;
            ret_nxt   = in_end_of_message ? ST_MARK : ST_IDLE;
          end else if (in_end_of_message) begin
            state_nxt = ST_MARK;
          end
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (rnd_r == LAST_ROUND) begin
          rnd_nxt   = '0;
          state_nxt = ST_ADD;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ret_r;
      end
      ST_MARK, ST_ZERO: begin
        cmd.put  = 1'b1;
        cmd.bsel = (state_r == ST_MARK) ? BSEL_MARK : BSEL_ZERO;
        if (sts.pos_last) begin
          cmd.start = 1'b1;
          state_nxt = ST_ROUND;
          ret_nxt   = ST_ZERO;
        end else if (sts.pos_pre_len) begin
          state_nxt = ST_LEN;
        end else begin
          state_nxt = ST_ZERO;
        end
      end
      ST_LEN: begin
        cmd.put  = 1'b1;
        cmd.bsel = BSEL_LEN;
        if (sts.pos_last) begin
          cmd.start = 1'b1;
          state_nxt = ST_ROUND;
          ret_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          cmd.out_shift = 1'b1;
          cmd.out_idx   = idx_r;
          if (idx_r == LAST_WORD) begin
            cmd.clear = 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
    end
  end

  `SHA1MD_ASSERT_IMP(a_rnd_range, clk, rst_n, state_r == ST_ROUND, rnd_r <= LAST_ROUND)
  `SHA1MD_ASSERT_IMP(a_idx_range, clk, rst_n, out_valid, idx_r <= LAST_WORD)
  `SHA1MD_ASSERT_NXT(a_round_done, clk, rst_n,
                     state_r == ST_ROUND && rnd_r == LAST_ROUND, state_r == ST_ADD)
  `SHA1MD_ASSERT_NXT(a_msg_done, clk, rst_n, out_valid && !out_stall && out_final_word,
                     state_r == ST_IDLE && idx_r == 3'd0)

endmodule

FILE: sv/sha1_message_digest.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------------
// in_      | input     | in_valid/in_stall  | data_byte[7:0], has_byte, end_of_message
// out_     | output    | out_valid/out_stall| digest_word[31:0], word_index[2:0], final_word
//
// A byte item is taken while the block is idle. The 64th byte of a block
//   starts 80 rounds through one shared round unit, then the chaining add.
// End of message: padding, one byte a cycle outside compression, to the block
//   end (one or two blocks), then five digest words, one a cycle if unstalled.
// Synchronous active-low reset loads the initial hash value and clears counters.
// in_stall is high whenever the block is not idle; out_stall holds the current word.
module sha1_message_digest import sha1md_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_final_word
);

  sha1md_cmd_t cmd;  // controller -> datapath
  sha1md_sts_t sts;  // datapath -> controller

  sha1md_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_word_index    (out_word_index),
    .out_final_word    (out_final_word),
    .sts               (sts),
    .cmd               (cmd)
  );

  // schedule line, working vars, chain value, length and byte counters
  sha1md_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_data_byte (in_data_byte),
    .sts          (sts),
    .digest_word  (out_digest_word)
  );

endmodule

FILE: sim/sha1_message_digest_tb.sv
`timescale 1ns / 1ps

module sha1_message_digest_tb;
  import sha1md_pkg::*;

  // Round constants, one per group of 20 rounds
  localparam logic [31:0] K_ROUNDS_00_19 = 32'h5A827999;
  localparam logic [31:0] K_ROUNDS_20_39 = 32'h6ED9EBA1;
  localparam logic [31:0] K_ROUNDS_40_59 = 32'h8F1BBCDC;
  localparam logic [31:0] K_ROUNDS_60_79 = 32'hCA62C1D6;

  // Random part size, in message items (bytes plus end markers)
  localparam int RANDOM_ITEMS   = 420;
  // Cycles with no transfer on either side before the run is abandoned.
  // Worst legit quiet stretch: long input gap, compression of two padded
  // blocks plus byte-wise padding, then a long output stall.
  localparam int WATCHDOG_LIMIT = 4000;
  // Settle time after the last digest word
  localparam int DRAIN_CYCLES   = 300;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  // Digest predictor plus the queue of digest words still owed by the block.
  class sha1_scoreboard;
    logic [31:0]  chain[5];
    logic [7:0]   block_buf[64];
    int unsigned  fill;
    logic [63:0]  bit_count;
    digest_word_t digest_q[$];
    int unsigned  fail_count;

    function new();
      fail_count = 0;
      restart();
    endfunction

    // Fresh message: initial hash value, empty block, zero length
    function void restart();
      chain[0]  = 32'h67452301;
      chain[1]  = 32'hefcdab89;
      chain[2]  = 32'h98badcfe;
      chain[3]  = 32'h10325476;
      chain[4]  = 32'hc3d2e1f0;
      fill      = 0;
      bit_count = '0;
    endfunction

    static function logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
    endfunction

    // 80 rounds over block_buf, rolling 16-word schedule
    function void compress();
      logic [31:0] w[16];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) begin
        w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
        if (r >= 16) begin
          w[r%16] = rotl(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
        end
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = K_ROUNDS_00_19;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = K_ROUNDS_20_39;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_ROUNDS_40_59;
        end else begin
          f = b ^ c ^ d;
          k = K_ROUNDS_60_79;
        end
        t = rotl(a, 5) + f + e + k + w[r%16];
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void note_input(input logic [7:0] data, input logic has, input logic eom);
      digest_word_t dw;
      if (has) begin
        block_buf[fill] = data;
        bit_count += 64'd8;
        fill++;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!eom) return;
      // Pad: marker byte, zeros, spill into a second block if the
      // length field no longer fits, then the big-endian bit count.
      block_buf[fill] = PAD_MARK_BYTE;
      for (int i = fill + 1; i < 64; i++) block_buf[i] = 8'h00;
      if (fill >= 56) begin
        compress();
        for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) block_buf[56+i] = bit_count[63-8*i -: 8];
      compress();
      for (int i = 0; i < 5; i++) begin
        dw.word = chain[i];
        dw.idx  = 3'(i);
        dw.last = (i == 4);
        digest_q.push_back(dw);
      end
      restart();
    endfunction

    task report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
    endtask

    task check_result(input logic [31:0] word, input logic [2:0] idx, input logic last);
      digest_word_t exp_w;
      if (digest_q.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h index %0d", word, idx));
        return;
      end
      exp_w = digest_q.pop_front();
      if (word !== exp_w.word)
        report_mismatch($sformatf("word %0d: got %h, want %h", exp_w.idx, word, exp_w.word));
      if (idx !== exp_w.idx)
        report_mismatch($sformatf("index: got %0d, want %0d", idx, exp_w.idx));
      if (last !== exp_w.last)
        report_mismatch($sformatf("final flag on word %0d: got %b", exp_w.idx, last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_has_byte = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_final_word;

  // Per-message switches: when set, that side starts no new gaps or stalls
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;
  int          stall_left = 0;
  int          idle_cycles = 0;

  sha1_scoreboard sb = new();

  sha1_message_digest dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_final_word    (out_final_word)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // One item: optional random gap with valid low, then hold it until taken.
  // in_stall is read right after the edge, i.e. the value the block saw.
  task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (in_quiet || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_has_byte       <= has;
    in_end_of_message <= eom;
    do @(posedge clk); while (in_stall);
    sb.note_input(data, has, eom);
  endtask

  // Result side back-pressure: mostly none or short, sometimes long
  always @(negedge clk) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (out_quiet || r < 70) begin
      out_stall <= 1'b0;
    end else if (r < 95) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(10, 40);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_digest_word, out_word_index, out_final_word);
    end
  end

  // Watchdog: any transfer on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("[sha1_message_digest] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          boundary_lens[9];
    int          random_items;
    int          msg_len;
    int unsigned r;
    bit          tail_byte;

    // Lengths around the padding and block edges: 55 is the longest that
    // keeps the length field in the same block, 64 fills a block exactly.
    boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
    random_items = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    send_item(8'hA5, 1'b0, 1'b0);   // neither flag: ignored, no digest
    send_item(8'h00, 1'b0, 1'b1);   // empty message
    send_item(8'h00, 1'b1, 1'b1);   // single zero byte
    send_item(8'hFF, 1'b1, 1'b1);   // single all-ones byte
    send_item(8'h61, 1'b1, 1'b0);   // "abc", known digest a9993e36...
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);   // bytes, stray no-op, then bare end
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'hC3, 1'b0, 1'b1);

    // Random messages: short ones mostly, boundary lengths a quarter of
    // the time, and the odd empty message. Some runs without idling.
    while (random_items < RANDOM_ITEMS) begin
      in_quiet  = ($urandom_range(0, 4) == 0);
      out_quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) msg_len = 0;
      else if (r < 35) msg_len = boundary_lens[$urandom_range(0, 8)];
      else msg_len = $urandom_range(1, 20);
      // end carried on the last byte, or on a separate byte-less item
      tail_byte = (msg_len != 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < msg_len; i++) begin
        if ($urandom_range(0, 14) == 0) send_item(8'($urandom), 1'b0, 1'b0);
        send_item(8'($urandom), 1'b1, tail_byte && (i == msg_len - 1));
        random_items++;
      end
      if (!tail_byte) begin
        send_item(8'($urandom), 1'b0, 1'b1);
        random_items++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0 && sb.digest_q.size() == 0) begin
      $display("[sha1_message_digest] OK");
    end else begin
      $display("[sha1_message_digest] ERROR");
    end
    $finish;
  end

endmodule
